// ===== hdl/sebd_pkg.sv =====
// Shared types, codes and constants of the sequencer event block decoder.
package sebd_pkg;

   localparam int SYSEX_DEPTH_DEF = 64;

   localparam logic [15:0] START_OFFSET_RST = 16'd384;
   localparam logic [32:0] TEMPO_DIVIDEND   = 33'd6000000000;
   localparam logic [23:0] TEMPO_SAT        = 24'hFFFFFF;
   localparam logic [6:0]  VEL_MAX          = 7'h7F;

   localparam logic [7:0] EV_POLY_AT    = 8'h8D;
   localparam logic [7:0] EV_CONTROL    = 8'h8E;
   localparam logic [7:0] EV_PROGRAM    = 8'h8F;
   localparam logic [7:0] EV_CHAN_AT    = 8'h90;
   localparam logic [7:0] EV_BEND       = 8'h91;
   localparam logic [7:0] EV_MUTE_TEMPO = 8'h93;
   localparam logic [7:0] EV_SX_SIZE    = 8'h95;
   localparam logic [7:0] EV_SX_DATA    = 8'h96;

   localparam logic [7:0] SUB_PART_MUTE = 8'h01;
   localparam logic [7:0] SUB_RHY_MUTE  = 8'h02;
   localparam logic [7:0] SUB_TEMPO     = 8'h03;

   localparam logic [7:0] SX_END         = 8'hF7;
   localparam logic [7:0] PART_LAST      = 8'h06;
   localparam logic [7:0] PART_RHYTHM    = 8'h09;
   localparam logic [7:0] PART_MUTE_CTRL = 8'h0E;

   typedef enum logic [3:0] {
      KIND_NOTE_ON,
      KIND_NOTE_OFF,
      KIND_POLY_AT,
      KIND_CONTROL,
      KIND_PROGRAM,
      KIND_CHAN_AT,
      KIND_BEND,
      KIND_TEMPO,
      KIND_PART_MUTE,
      KIND_RHY_MUTE,
      KIND_SYSEX
   } sebd_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_NOTE_ON,
      ST_NOTE_OFF,
      ST_SINGLE,
      ST_DIV_WAIT,
      ST_SX_BYTE,
      ST_SX_READ,
      ST_SX_EMIT
   } sebd_state_type;

   typedef struct packed {
      logic       new_pattern;
      logic [7:0] tick_increment;
      logic [7:0] event_code;
      logic [7:0] part_code;
      logic [7:0] byte_four;
      logic [7:0] byte_five;
      logic [7:0] byte_six;
      logic [7:0] byte_seven;
   } sebd_req_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [4:0]  channel;
      logic [7:0]  first_value;
      logic [13:0] second_value;
      logic [23:0] tempo_micros;
      logic [31:0] event_time;
      logic        last;
   } sebd_rsp_type;

endpackage

// ===== hdl/sequencer_event_block_decoder_top.sv =====
// Top level of the sequencer event block decoder.
//
// Requests arrive on req_valid/req_ready with one event block (seven bytes and a
// new-pattern flag) in req_payload; timestamped events leave on rsp_valid/rsp_ready in rsp_payload,
// with last set on the final event of each request. csr_write_enable and
// csr_write_data load the 16-bit start offset.
// One request is in work at a time: taken in IDLE, decoded in DISPATCH,
// which returns to IDLE if it makes no event. Note pairs pass NOTE_ON and
// NOTE_OFF, single events SINGLE; a tempo block waits first in DIV_WAIT
// for the 33-step bit-serial divider. SysEx data is stored one byte per cycle;
// on F7 the run is read back from the SysEx RAM through its registered read port.
// Events pass through one output register, so the next request is taken
// while the last event of the previous one waits; a stalled receiver holds
// that register and, with it, the sequencer.
// Synchronous reset sets the start offset to 384, the running time to it,
// and empties the SysEx size and fill count; RAM contents are not cleared.
module sequencer_event_block_decoder_top #(
   parameter int SYSEX_DEPTH = sebd_pkg::SYSEX_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sebd_pkg::sebd_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sebd_pkg::sebd_rsp_type rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data
);

   localparam int AW = $clog2(SYSEX_DEPTH);
   localparam int CW = $clog2(SYSEX_DEPTH + 1);

   sebd_pkg::sebd_state_type state_ff, state_in;
   logic [15:0]              start_offset_ff, start_offset_in;
   logic [31:0]              run_time_ff, run_time_in;
   logic [31:0]              now_ff, now_in;
   sebd_pkg::sebd_req_type   req_ff, req_in;
   logic [CW-1:0]            sx_size_ff, sx_size_in;
   logic [CW-1:0]            sx_fill_ff, sx_fill_in;
   logic [1:0]               byte_idx_ff, byte_idx_in;
   logic [CW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sebd_pkg::sebd_rsp_type   rsp_ff, rsp_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   out_load;
   sebd_pkg::sebd_rsp_type out_data;
   logic                   part_ok;
   logic [7:0]             pay;
   logic                   sx_room;
   logic [CW-1:0]          rd_idx_next;
   logic                   sx_last;
   logic [31:0]            now_v;
   logic [31:0]            sx_req_size;
   logic [6:0]             vel;

   logic          div_start;
   logic          div_done;
   logic [23:0]   div_quot;

   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [7:0]    ram_rd_data;

   sebd_ram #(
      .WIDTH(8),
      .DEPTH(SYSEX_DEPTH)
   ) u_sx_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(sx_fill_ff[AW-1:0]),
      .wr_data(pay),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   sebd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor ({req_ff.byte_six, req_ff.byte_seven}),
      .done    (div_done),
      .quotient(div_quot)
   );

   assign req_ready   = (state_ff == sebd_pkg::ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign part_ok = req_ff.part_code inside {[8'h00:sebd_pkg::PART_LAST],
                                             sebd_pkg::PART_RHYTHM,
                                             sebd_pkg::PART_MUTE_CTRL};
   assign sx_room     = sx_fill_ff < sx_size_ff;
   assign rd_idx_next = rd_idx_ff + CW'(1);
   assign sx_last     = (rd_idx_next == sx_fill_ff);
   assign vel         = req_ff.byte_four[7] ? sebd_pkg::VEL_MAX : req_ff.byte_four[6:0];
   assign sx_req_size = {req_ff.byte_four, req_ff.byte_five, req_ff.byte_six,
                         req_ff.byte_seven};
   assign now_v       = req_payload.new_pattern ? {16'h0000, start_offset_ff} : run_time_ff;

   always_comb begin
      case (byte_idx_ff)
         2'd0:    pay = req_ff.byte_four;
         2'd1:    pay = req_ff.byte_five;
         2'd2:    pay = req_ff.byte_six;
         default: pay = req_ff.byte_seven;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sebd_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sebd_pkg::ST_DISPATCH;
            end
         end
         sebd_pkg::ST_DISPATCH: begin
            state_in = sebd_pkg::ST_IDLE;
            if (part_ok) begin
               if (!req_ff.event_code[7]) begin
                  state_in = sebd_pkg::ST_NOTE_ON;
               end else begin
                  case (req_ff.event_code)
                     sebd_pkg::EV_POLY_AT,
                     sebd_pkg::EV_CONTROL,
                     sebd_pkg::EV_PROGRAM,
                     sebd_pkg::EV_CHAN_AT,
                     sebd_pkg::EV_BEND: state_in = sebd_pkg::ST_SINGLE;
                     sebd_pkg::EV_MUTE_TEMPO: begin
                        if (req_ff.byte_four inside {sebd_pkg::SUB_PART_MUTE,
                                                     sebd_pkg::SUB_RHY_MUTE}) begin
                           state_in = sebd_pkg::ST_SINGLE;
                        end else if (req_ff.byte_four == sebd_pkg::SUB_TEMPO) begin
                           state_in = sebd_pkg::ST_DIV_WAIT;
                        end
                     end
                     sebd_pkg::EV_SX_DATA: state_in = sebd_pkg::ST_SX_BYTE;
                     default:              state_in = sebd_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         sebd_pkg::ST_NOTE_ON: begin
            if (out_free) begin
               state_in = sebd_pkg::ST_NOTE_OFF;
            end
         end
         sebd_pkg::ST_NOTE_OFF,
         sebd_pkg::ST_SINGLE: begin
            if (out_free) begin
               state_in = sebd_pkg::ST_IDLE;
            end
         end
         sebd_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = sebd_pkg::ST_SINGLE;
            end
         end
         sebd_pkg::ST_SX_BYTE: begin
            if (!sx_room) begin
               state_in = sebd_pkg::ST_IDLE;
            end else if (pay == sebd_pkg::SX_END) begin
               state_in = sebd_pkg::ST_SX_READ;
            end else if (byte_idx_ff == 2'd3) begin
               state_in = sebd_pkg::ST_IDLE;
            end
         end
         sebd_pkg::ST_SX_READ: begin
            state_in = sebd_pkg::ST_SX_EMIT;
         end
         sebd_pkg::ST_SX_EMIT: begin
            if (out_free) begin
               state_in = sx_last ? sebd_pkg::ST_IDLE : sebd_pkg::ST_SX_READ;
            end
         end
         default: state_in = sebd_pkg::ST_IDLE;
      endcase
   end

   // event builder
   always_comb begin
      out_data              = '0;
      out_data.channel      = req_ff.part_code[4:0] + 5'd1;
      out_data.event_time   = now_ff;
      out_data.last         = 1'b1;
      out_load              = 1'b0;
      case (state_ff)
         sebd_pkg::ST_NOTE_ON: begin
            out_load              = out_free;
            out_data.event_kind   = sebd_pkg::KIND_NOTE_ON;
            out_data.first_value  = req_ff.event_code;
            out_data.second_value = {7'b0, vel};
            out_data.last         = 1'b0;
         end
         sebd_pkg::ST_NOTE_OFF: begin
            out_load             = out_free;
            out_data.event_kind  = sebd_pkg::KIND_NOTE_OFF;
            out_data.first_value = req_ff.event_code;
            out_data.event_time  = now_ff + {16'h0000, req_ff.byte_six, req_ff.byte_seven};
         end
         sebd_pkg::ST_SINGLE: begin
            out_load = out_free;
            case (req_ff.event_code)
               sebd_pkg::EV_POLY_AT: begin
                  out_data.event_kind   = sebd_pkg::KIND_POLY_AT;
                  out_data.first_value  = {1'b0, req_ff.byte_five[6:0]};
                  out_data.second_value = {7'b0, req_ff.byte_six[6:0]};
               end
               sebd_pkg::EV_CONTROL: begin
                  out_data.event_kind   = sebd_pkg::KIND_CONTROL;
                  out_data.first_value  = {1'b0, req_ff.byte_five[6:0]};
                  out_data.second_value = {7'b0, req_ff.byte_six[6:0]};
               end
               sebd_pkg::EV_PROGRAM: begin
                  out_data.event_kind  = sebd_pkg::KIND_PROGRAM;
                  out_data.first_value = {1'b0, req_ff.byte_five[6:0]};
               end
               sebd_pkg::EV_CHAN_AT: begin
                  out_data.event_kind  = sebd_pkg::KIND_CHAN_AT;
                  out_data.first_value = {1'b0, req_ff.byte_five[6:0]};
               end
               sebd_pkg::EV_BEND: begin
                  out_data.event_kind   = sebd_pkg::KIND_BEND;
                  out_data.second_value = {req_ff.byte_five[6:0], req_ff.byte_six[6:0]};
               end
               default: begin
                  case (req_ff.byte_four)
                     sebd_pkg::SUB_PART_MUTE: begin
                        out_data.event_kind   = sebd_pkg::KIND_PART_MUTE;
                        out_data.first_value  = req_ff.byte_five;
                        out_data.second_value = {6'b0, req_ff.byte_seven};
                     end
                     sebd_pkg::SUB_RHY_MUTE: begin
                        out_data.event_kind   = sebd_pkg::KIND_RHY_MUTE;
                        out_data.first_value  = req_ff.byte_five;
                        out_data.second_value = {6'b0, req_ff.byte_seven};
                     end
                     default: begin
                        out_data.event_kind   = sebd_pkg::KIND_TEMPO;
                        out_data.tempo_micros = div_quot;
                     end
                  endcase
               end
            endcase
         end
         sebd_pkg::ST_SX_EMIT: begin
            out_load             = out_free;
            out_data.event_kind  = sebd_pkg::KIND_SYSEX;
            out_data.first_value = ram_rd_data;
            out_data.last        = sx_last;
         end
         default: out_load = 1'b0;
      endcase
   end

   assign div_start = (state_ff == sebd_pkg::ST_DISPATCH) && (state_in == sebd_pkg::ST_DIV_WAIT);
   assign ram_wr_en = (state_ff == sebd_pkg::ST_SX_BYTE) && sx_room;
   assign ram_rd_en = (state_ff == sebd_pkg::ST_SX_READ);

   // register updates
   always_comb begin
      start_offset_in = start_offset_ff;
      run_time_in     = run_time_ff;
      now_in          = now_ff;
      req_in          = req_ff;
      sx_size_in      = sx_size_ff;
      sx_fill_in      = sx_fill_ff;
      byte_idx_in     = byte_idx_ff;
      rd_idx_in       = rd_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;

      if (csr_write_enable) begin
         start_offset_in = csr_write_data;
      end

      if (req_fire) begin
         req_in      = req_payload;
         now_in      = now_v;
         run_time_in = now_v + {24'h000000, req_payload.tick_increment};
         if (req_payload.new_pattern) begin
            sx_size_in = '0;
            sx_fill_in = '0;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_data;
      end

      case (state_ff)
         sebd_pkg::ST_DISPATCH: begin
            byte_idx_in = 2'd0;
            if (part_ok && (req_ff.event_code == sebd_pkg::EV_SX_SIZE)) begin
               sx_size_in = (sx_req_size > 32'(SYSEX_DEPTH)) ? CW'(SYSEX_DEPTH)
                                                             : sx_req_size[CW-1:0];
               sx_fill_in = '0;
            end
         end
         sebd_pkg::ST_SX_BYTE: begin
            if (sx_room) begin
               sx_fill_in  = sx_fill_ff + CW'(1);
               byte_idx_in = byte_idx_ff + 2'd1;
               rd_idx_in   = '0;
            end
         end
         sebd_pkg::ST_SX_EMIT: begin
            if (out_free) begin
               rd_idx_in = rd_idx_next;
               if (sx_last) begin
                  sx_size_in = '0;
                  sx_fill_in = '0;
               end
            end
         end
         default: rd_idx_in = rd_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= sebd_pkg::ST_IDLE;
         start_offset_ff <= sebd_pkg::START_OFFSET_RST;
         run_time_ff     <= {16'h0000, sebd_pkg::START_OFFSET_RST};
         sx_size_ff      <= '0;
         sx_fill_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         start_offset_ff <= start_offset_in;
         run_time_ff     <= run_time_in;
         sx_size_ff      <= sx_size_in;
         sx_fill_ff      <= sx_fill_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      req_ff      <= req_in;
      byte_idx_ff <= byte_idx_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== hdl/sebd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sebd_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sebd_div.sv =====
// Bit-serial tempo divider: fixed dividend over a 16-bit divisor, saturated to 24 bits.
module sebd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [23:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [23:0] quot_ff, quot_in;
   logic        sat_ff, sat_in;

   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, sebd_pkg::TEMPO_DIVIDEND[cnt_ff]};
      ge      = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         div_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[15:0] : rem_sh[15:0];
         quot_in = {quot_ff[22:0], ge};
         sat_in  = sat_ff | (ge && (cnt_ff >= 6'd24));
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? sebd_pkg::TEMPO_SAT : quot_ff;

endmodule
